@@ rtl/fp4_pair_dequant_to_bf16_core_defines.svh @@
// Assertion macros for the fp4 pair dequantiser
`ifndef FP4_PAIR_DEQUANT_TO_BF16_CORE_DEFINES_SVH
`define FP4_PAIR_DEQUANT_TO_BF16_CORE_DEFINES_SVH

// clocked check, masked during reset
`define FPDQ_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("fpdq check failed");

// clocked check that also holds through reset
`define FPDQ_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("fpdq check failed");

`endif

@@ rtl/fpdq_pkg.sv @@
`default_nettype none
package fpdq_pkg;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [31:0] QNAN_CODE   = 32'h7FC0_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] BF16_BIAS   = 32'h0000_7FFF;
  localparam logic [15:0] BF16_QNAN   = 16'h7FC0;

  localparam logic [1:0] CODE_EXP_SUB = 2'd0;
  localparam logic [1:0] CODE_EXP_ONE = 2'd1;
  localparam logic [1:0] CODE_EXP_TWO = 2'd2;
  localparam logic [1:0] CODE_EXP_SPC = 2'd3;

  localparam logic [3:0] CODE_NAN_POS = 4'h7;
  localparam logic [3:0] CODE_NAN_NEG = 4'hF;

endpackage
`default_nettype wire

@@ rtl/fpdq_lane.sv @@
`default_nettype none
module fpdq_lane (
  input  wire logic [31:0] scale,
  input  wire logic [3:0]  code,
  output logic      [15:0] bf16
);

  logic               s_sign, c_sign, sign;
  logic        [7:0]  se;
  logic        [22:0] sf;
  logic               s_nan, s_inf, s_zero;
  logic        [1:0]  ce;
  logic               cm;
  logic               c_nan, c_inf, c_zero;
  logic        [23:0] sig;
  logic        [25:0] prod;
  logic signed [10:0] x, t, lp, er_m1, sh_a, sh_b, sh_s;
  logic        [8:0]  base;
  logic        [1:0]  sh;
  logic        [25:0] r, r_rnd;
  logic               g, st;
  logic        [32:0] mag;
  logic        [31:0] p, sum;

  always_comb begin
    s_sign = scale[31];
    se     = scale[30:23];
    sf     = scale[22:0];
    s_nan  = (se == 8'hFF) && (sf != 23'd0);
    s_inf  = (se == 8'hFF) && (sf == 23'd0);
    s_zero = (se == 8'd0) && (sf == 23'd0);
    c_sign = code[3];
    ce     = code[2:1];
    cm     = code[0];
    c_nan  = (ce == fpdq_pkg::CODE_EXP_SPC) && cm;
    c_inf  = (ce == fpdq_pkg::CODE_EXP_SPC) && !cm;
    c_zero = (ce == fpdq_pkg::CODE_EXP_SUB) && !cm;
    sign   = s_sign ^ c_sign;

    case (ce)
      fpdq_pkg::CODE_EXP_SUB: x = -11'sd3;
      fpdq_pkg::CODE_EXP_ONE: x = -11'sd1;
      default:                x = 11'sd0;
    endcase

    sig  = {se != 8'd0, sf};
    prod = ({2'b00, sig} << 1)
         + ((cm && (ce != fpdq_pkg::CODE_EXP_SUB)) ? {2'b00, sig} : 26'd0);

    t  = $signed({3'b000, ((se == 8'd0) ? 8'd1 : se)}) + x;
    lp = prod[25] ? 11'sd25 : (prod[24] ? 11'sd24 : 11'sd23);
    er_m1 = lp + t - 11'sd24;
    base  = (er_m1 > 11'sd0) ? er_m1[8:0] : 9'd0;
    sh_a  = lp - 11'sd23;
    sh_b  = 11'sd1 - t;
    sh_s  = (sh_a > sh_b) ? sh_a : sh_b;
    sh    = sh_s[1:0];

    case (sh)
      2'd0: begin
        r = prod; g = 1'b0; st = 1'b0;
      end
      2'd1: begin
        r = prod >> 1; g = prod[0]; st = 1'b0;
      end
      2'd2: begin
        r = prod >> 2; g = prod[1]; st = prod[0];
      end
      default: begin
        r = prod >> 3; g = prod[2]; st = |prod[1:0];
      end
    endcase
    r_rnd = r + {25'd0, g && (st || r[0])};
    mag   = {1'b0, base, 23'd0} + {7'd0, r_rnd};

    if (c_nan) begin
      p = fpdq_pkg::QNAN_CODE;
    end else if (s_nan) begin
      p = scale | fpdq_pkg::QUIET_BIT;
    end else if ((c_inf && s_zero) || (c_zero && s_inf)) begin
      p = fpdq_pkg::DEFAULT_NAN;
    end else if (c_inf || s_inf || (mag >= 33'h0_7F80_0000)) begin
      p = {sign, 8'hFF, 23'd0};
    end else if (c_zero || s_zero) begin
      p = {sign, 31'd0};
    end else begin
      p = {sign, mag[30:0]};
    end

    sum  = p + fpdq_pkg::BF16_BIAS + {31'd0, p[16]};
    bf16 = sum[31:16];
  end

endmodule
`default_nettype wire

@@ rtl/fp4_pair_dequant_to_bf16_core.sv @@
// A request passes the input register, then the result register; both lanes decode,
// scale and round in one pass. Throughput: one packed byte per cycle when not stalled.
// A request is still taken while a result waits, as long as the input register is free.
// Reset (rst, synchronous, active high) empties both registers and sets the scale to 1.0.
`default_nettype none
`include "fp4_pair_dequant_to_bf16_core_defines.svh"
module fp4_pair_dequant_to_bf16_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  packed_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] first_bf16,
  output logic      [15:0] second_bf16,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] scale_bits
);

  logic [31:0] scale;
  logic        byte_valid;
  logic [7:0]  byte_q;
  logic        out_en, byte_en;
  logic [15:0] lo_bf16, hi_bf16;

  assign cfg_ready = 1'b1;
  assign out_en    = !out_valid || !out_stall;
  assign byte_en   = !byte_valid || out_en;
  assign in_stall  = !byte_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= fpdq_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale <= scale_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (byte_en) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && in_valid) begin
      byte_q <= packed_byte;
    end
  end

  fpdq_lane u_lo (
    .scale (scale),
    .code  (byte_q[3:0]),
    .bf16  (lo_bf16)
  );

  fpdq_lane u_hi (
    .scale (scale),
    .code  (byte_q[7:4]),
    .bf16  (hi_bf16)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && byte_valid) begin
      first_bf16  <= lo_bf16;
      second_bf16 <= hi_bf16;
    end
  end

  `FPDQ_ASSERT(a_in_lands, clk, rst, (in_valid && !in_stall) |=> byte_valid)
  `FPDQ_ASSERT(a_moves_out, clk, rst, (byte_valid && out_en) |=> out_valid)
  `FPDQ_ASSERT(a_full_stalls, clk, rst, (byte_valid && out_valid && out_stall) |-> in_stall)
  `FPDQ_ASSERT(a_nan_lo, clk, rst,
    (byte_valid && out_en && ((byte_q[3:0] == fpdq_pkg::CODE_NAN_POS) ||
     (byte_q[3:0] == fpdq_pkg::CODE_NAN_NEG))) |=> (first_bf16 == fpdq_pkg::BF16_QNAN))
  `FPDQ_ASSERT_ALWAYS(a_cfg_open, clk, cfg_ready)

endmodule
`default_nettype wire
